[rtl/tcpnr_pkg.sv]
// Package: payload structs, register indexes and sequencer states for the NewReno sender.
package tcpnr_pkg;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_ACK   = 2'd1,
    OP_SEND  = 2'd2,
    OP_TIMER = 2'd3
  } op_t;

  localparam logic [2:0] REG_SEGMENT_SIZE = 3'd0;
  localparam logic [2:0] REG_FLOW_BYTES   = 3'd1;
  localparam logic [2:0] REG_WINDOW_CAP   = 3'd2;
  localparam logic [2:0] REG_MIN_RTO      = 3'd3;
  localparam logic [2:0] REG_INITIAL_RTO  = 3'd4;
  localparam logic [2:0] REG_INIT_WINDOW  = 3'd5;
  localparam logic [2:0] REG_DUP_THRESH   = 3'd6;

  localparam logic [31:0] ALL32 = 32'hffff_ffff;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] ack_seq;
    logic [31:0] rtt_sample;
    logic [47:0] now_ticks;
  } in_word_t;

  typedef struct packed {
    logic        send_granted;
    logic [31:0] send_seq;
    logic        retransmit;
    logic [31:0] retransmit_seq;
    logic [31:0] window_bytes;
    logic [31:0] slow_start_threshold;
    logic [31:0] timeout_ticks;
    logic        recovering;
    logic        flow_done;
    logic        connected;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_FINISH,
    ST_OUT
  } state_t;

endpackage

[rtl/tcp_newreno_sender_window.sv]
// Top level: NewReno sender window engine with an iterative divider.
//
// Usage: one operation word enters on in_valid/in_stall; exactly one status
// word leaves on out_valid/out_stall for each. Configuration registers are
// written on cfg_valid/cfg_ready (index, data); cfg_ready is high only while
// the block is idle. Writing the initial RTO also reloads the current RTO.
// Sequencing: each word passes ST_MUL, ST_FINISH and ST_OUT, where out_valid
// rises. An ack that does additive increase forms segment_size*room in
// ST_MUL, then runs a 32-step restoring divide (one quotient bit a cycle) in
// ST_DIV for segment_size*room/window before ST_FINISH.
// The block accepts one word at a time: in_stall is high from acceptance
// until the result word is taken.
// Reset (rst_n low, synchronous) loads the register defaults and resets all
// connection state; the RTO returns to its default of 3000000.
// While out_stall is high the result word holds and no new word is taken.
module tcp_newreno_sender_window (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  tcpnr_pkg::in_word_t in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output tcpnr_pkg::out_word_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data
);

  // configuration
  logic [15:0] seg_r;
  logic [31:0] flow_r, cap_r, minrto_r;
  logic [9:0]  initwin_r;
  logic [3:0]  dupth_r;

  // connection state
  logic [31:0] win_r, win_nxt, thr_r, thr_nxt, acked_r, acked_nxt, sent_r, sent_nxt;
  logic [31:0] recov_r, recov_nxt, srtt_r, srtt_nxt, rttvar_r, rttvar_nxt, rto_r, rto_nxt;
  logic [3:0]  dup_r, dup_nxt;
  logic [47:0] dl_r, dl_nxt;
  logic        armed_r, armed_nxt, fr_r, fr_nxt, conn_r, conn_nxt, done_r, done_nxt;

  // sequencer and divider
  tcpnr_pkg::state_t st_r, st_nxt;
  tcpnr_pkg::in_word_t in_r, in_nxt;
  tcpnr_pkg::out_word_t out_r, out_nxt;
  logic [31:0] num_r, num_nxt;   // dividend shifting out
  logic [31:0] rem_r, rem_nxt, quo_r, quo_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        div_r, div_nxt;   // divide result pending for this word

  assign in_stall  = (st_r != tcpnr_pkg::ST_IDLE);
  assign out_valid = (st_r == tcpnr_pkg::ST_OUT);
  assign out_data  = out_r;
  assign cfg_ready = (st_r == tcpnr_pkg::ST_IDLE);

  // shared helpers
  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [33:0] b);
    logic [34:0] s;
    s = {3'd0, a} + {1'b0, b};
    return (s[34:32] != 3'd0) ? tcpnr_pkg::ALL32 : s[31:0];
  endfunction

  function automatic logic [31:0] half_thr(input logic [31:0] w, input logic [15:0] s);
    logic [31:0] two;
    two = {15'd0, s, 1'b0};
    return ({1'b0, w[31:1]} > two) ? {1'b0, w[31:1]} : two;
  endfunction

  logic [31:0] flow_len;
  assign flow_len = (flow_r < {16'd0, seg_r}) ? {16'd0, seg_r} : flow_r;

  // combinational ack/send/timer evaluation
  logic [31:0] seq, m, d, lim, fresh, w1;
  logic [47:0] now;
  logic [33:0] rm;
  logic [32:0] room;
  logic [3:0]  dupi;
  logic        rtx, grant;
  logic [31:0] gseq;

  always_comb begin
    st_nxt = st_r; in_nxt = in_r; out_nxt = out_r;
    win_nxt = win_r; thr_nxt = thr_r; acked_nxt = acked_r; sent_nxt = sent_r;
    recov_nxt = recov_r; srtt_nxt = srtt_r; rttvar_nxt = rttvar_r; rto_nxt = rto_r;
    dup_nxt = dup_r; dl_nxt = dl_r; armed_nxt = armed_r; fr_nxt = fr_r;
    conn_nxt = conn_r; done_nxt = done_r;
    num_nxt = num_r; rem_nxt = rem_r; quo_nxt = quo_r; cnt_nxt = cnt_r; div_nxt = div_r;
    seq = in_r.ack_seq; m = in_r.rtt_sample; now = in_r.now_ticks;
    d = '0; lim = '0; fresh = '0; w1 = '0; rm = '0; room = '0; dupi = '0;
    rtx = 1'b0; grant = 1'b0; gseq = '0;
    case (st_r)
      tcpnr_pkg::ST_IDLE: begin
        // initial RTO write reloads the live RTO
        if (cfg_valid && cfg_index == tcpnr_pkg::REG_INITIAL_RTO) rto_nxt = cfg_data;
        if (in_valid) begin
          in_nxt = in_data;
          cnt_nxt = '0;
          div_nxt = 1'b0;
          st_nxt = tcpnr_pkg::ST_MUL;
        end
      end
      // decode stage: everything but the additive-increase divide
      tcpnr_pkg::ST_MUL: begin
        st_nxt = tcpnr_pkg::ST_FINISH;
        case (tcpnr_pkg::op_t'(in_r.op))
          tcpnr_pkg::OP_START: begin
            win_nxt = 32'(initwin_r * seg_r);
            conn_nxt = 1'b0;
          end
          tcpnr_pkg::OP_ACK: begin
            if (seq >= acked_r) begin
              if (seq == 32'd1) conn_nxt = 1'b1;
              // RTT smoothing
              if (m != 0) begin
                if (srtt_r != 0) begin
                  d = (m > srtt_r) ? m - srtt_r : srtt_r - m;
                  rttvar_nxt = 32'(({2'd0, rttvar_r} * 34'd3) >> 2) + (d >> 2);
                  srtt_nxt = 32'(({3'd0, srtt_r} * 35'd7) >> 3) + (m >> 3);
                end else begin
                  srtt_nxt = m;
                  rttvar_nxt = m >> 1;
                end
                rto_nxt = sat_add(srtt_nxt, {rttvar_nxt, 2'b00});
              end
              if (rto_nxt < minrto_r) rto_nxt = minrto_r;
              if (seq >= flow_len) done_nxt = 1'b1;
              if (seq > acked_r) begin
                dl_nxt = now + {16'd0, rto_nxt};
                armed_nxt = 1'b1;
                if (seq >= sent_r) begin
                  sent_nxt = seq;
                  armed_nxt = 1'b0;
                end
                if (!fr_r) begin
                  acked_nxt = seq; dup_nxt = '0;
                  room = 33'({1'b0, seq} + {1'b0, win_r}) - {1'b0, sent_nxt};
                  // room as signed 33-bit; clamp to segment_size
                  if (!room[32]) begin
                    if (room[31:0] > {16'd0, seg_r}) room = {17'd0, seg_r};
                    if (win_r < thr_r) begin
                      w1 = thr_r - win_r;
                      win_nxt = win_r + ((room[31:0] < w1) ? room[31:0] : w1);
                      if (win_nxt > cap_r) win_nxt = cap_r;
                    end else if (win_r != 0) begin
                      div_nxt = 1'b1;
                      num_nxt = 32'(room[15:0] * seg_r);
                      rem_nxt = '0; quo_nxt = '0; cnt_nxt = 6'd32;
                      st_nxt = tcpnr_pkg::ST_DIV;
                    end else if (win_r > cap_r) win_nxt = cap_r;
                  end else if (win_r > cap_r) win_nxt = cap_r;
                end else if (seq >= recov_r) begin
                  lim = sent_nxt - seq;
                  rm = {2'd0, lim} + {18'd0, seg_r};
                  win_nxt = (rm < {2'd0, thr_r}) ? rm[31:0] : thr_r;
                  acked_nxt = seq; dup_nxt = '0; fr_nxt = 1'b0;
                end else begin
                  fresh = seq - acked_r;
                  acked_nxt = seq;
                  w1 = (fresh < win_r) ? win_r - fresh : '0;
                  win_nxt = sat_add(w1, {18'd0, seg_r});
                  rtx = 1'b1;
                  if (!armed_nxt) begin
                    dl_nxt = now + {16'd0, rto_nxt}; armed_nxt = 1'b1;
                  end
                end
              end else if (fr_r) begin
                win_nxt = sat_add(win_r, {18'd0, seg_r});
                if (win_nxt > cap_r) win_nxt = cap_r;
              end else if (dup_r != 4'd15) begin
                dupi = dup_r + 4'd1;
                dup_nxt = dupi;
                if (dupi == dupth_r && acked_r >= recov_r) begin
                  thr_nxt = half_thr(win_r, seg_r);
                  rtx = 1'b1;
                  if (!armed_r) begin
                    dl_nxt = now + {16'd0, rto_nxt}; armed_nxt = 1'b1;
                  end
                  win_nxt = sat_add(thr_nxt, 34'({18'd0, seg_r} * 34'd3));
                  fr_nxt = 1'b1;
                  recov_nxt = sent_r;
                end
              end
            end
          end
          tcpnr_pkg::OP_SEND: begin
            if (!conn_r) begin
              grant = 1'b1; gseq = 32'd1; sent_nxt = 32'd1;
              if (!armed_r) begin
                dl_nxt = now + {16'd0, rto_r}; armed_nxt = 1'b1;
              end
            end else if (({1'b0, acked_r} + {1'b0, win_r}) >=
                         ({1'b0, sent_r} + {17'd0, seg_r}) && sent_r < flow_len) begin
              grant = 1'b1; gseq = sent_r + 32'd1;
              sent_nxt = sat_add(sent_r, {18'd0, seg_r});
              if (!armed_r) begin
                dl_nxt = now + {16'd0, rto_r}; armed_nxt = 1'b1;
              end
            end
          end
          default: begin
            if (!done_r && armed_r && now > dl_r && sent_r != 0) begin
              rto_nxt = sat_add(rto_r, {2'd0, rto_r});
              dl_nxt = now + {16'd0, rto_nxt};
              w1 = win_r;
              if (fr_r) begin
                rm = {2'd0, sent_r - acked_r} + {18'd0, seg_r};
                w1 = (rm < {2'd0, thr_r}) ? rm[31:0] : thr_r;
              end
              thr_nxt = half_thr(w1, seg_r);
              win_nxt = {16'd0, seg_r};
              fr_nxt = 1'b0;
              recov_nxt = sent_r;
              if (conn_r) sent_nxt = sat_add(acked_r, {18'd0, seg_r});
              dup_nxt = '0;
              rtx = 1'b1;
            end
          end
        endcase
        out_nxt.send_granted = grant;
        out_nxt.send_seq = gseq;
        out_nxt.retransmit = rtx;
        out_nxt.retransmit_seq = rtx ? (conn_nxt ? acked_nxt + 32'd1 : 32'd1) : '0;
      end
      // restoring divide, one quotient bit per cycle
      tcpnr_pkg::ST_DIV: begin
        rm = {1'b0, rem_r, num_r[31]};
        num_nxt = {num_r[30:0], 1'b0};
        if (rm >= {2'd0, win_r}) begin
          rem_nxt = 32'(rm - {2'd0, win_r});
          quo_nxt = {quo_r[30:0], 1'b1};
        end else begin
          rem_nxt = rm[31:0];
          quo_nxt = {quo_r[30:0], 1'b0};
        end
        cnt_nxt = cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          st_nxt = tcpnr_pkg::ST_FINISH;
        end
      end
      tcpnr_pkg::ST_FINISH: begin
        if (in_r.op == tcpnr_pkg::OP_ACK && div_r) begin
          w1 = sat_add(win_r, {2'd0, quo_r});
          win_nxt = (w1 > cap_r) ? cap_r : w1;
          div_nxt = 1'b0;
        end
        out_nxt.window_bytes = win_nxt;
        out_nxt.slow_start_threshold = thr_r;
        out_nxt.timeout_ticks = rto_r;
        out_nxt.recovering = fr_r;
        out_nxt.flow_done = done_r;
        out_nxt.connected = conn_r;
        st_nxt = tcpnr_pkg::ST_OUT;
      end
      tcpnr_pkg::ST_OUT: begin
        if (!out_stall) st_nxt = tcpnr_pkg::ST_IDLE;
      end
      default: st_nxt = tcpnr_pkg::ST_IDLE;
    endcase
  end

  // state and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= tcpnr_pkg::ST_IDLE;
      seg_r <= 16'd1500; flow_r <= tcpnr_pkg::ALL32; cap_r <= tcpnr_pkg::ALL32;
      minrto_r <= 32'd10000; initwin_r <= 10'd100;
      dupth_r <= 4'd3;
      win_r <= '0; thr_r <= tcpnr_pkg::ALL32; acked_r <= '0; sent_r <= '0;
      recov_r <= '0; dup_r <= '0; srtt_r <= '0; rttvar_r <= '0;
      rto_r <= 32'd3000000; dl_r <= '0; armed_r <= 1'b0; fr_r <= 1'b0;
      conn_r <= 1'b0; done_r <= 1'b0; cnt_r <= '0; div_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      win_r <= win_nxt; thr_r <= thr_nxt; acked_r <= acked_nxt; sent_r <= sent_nxt;
      recov_r <= recov_nxt; dup_r <= dup_nxt; srtt_r <= srtt_nxt; rttvar_r <= rttvar_nxt;
      rto_r <= rto_nxt; dl_r <= dl_nxt; armed_r <= armed_nxt; fr_r <= fr_nxt;
      conn_r <= conn_nxt; done_r <= done_nxt; cnt_r <= cnt_nxt; div_r <= div_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          tcpnr_pkg::REG_SEGMENT_SIZE: seg_r <= cfg_data[15:0];
          tcpnr_pkg::REG_FLOW_BYTES:   flow_r <= cfg_data;
          tcpnr_pkg::REG_WINDOW_CAP:   cap_r <= cfg_data;
          tcpnr_pkg::REG_MIN_RTO:      minrto_r <= cfg_data;
          tcpnr_pkg::REG_INIT_WINDOW:  initwin_r <= cfg_data[9:0];
          tcpnr_pkg::REG_DUP_THRESH:   dupth_r <= cfg_data[3:0];
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    in_r <= in_nxt; out_r <= out_nxt;
    num_r <= num_nxt; rem_r <= rem_nxt; quo_r <= quo_nxt;
  end

endmodule
